### hw/rtl/bpcc_pkg.sv
// ----------------------------------------------------------------------------
// bpcc_pkg
// Shared types, constants and codes of the port channel combiner.
// ----------------------------------------------------------------------------
package bpcc_pkg;

    localparam int MAX_ELEMS = 64;
    localparam int MAX_PORTS = 8;
    localparam int ACC_WIDTH = 48;

    localparam int ELEM_W    = 6;
    localparam int SLOT_W    = $clog2(MAX_ELEMS);
    localparam int PORT_W    = 3;
    localparam int PAIR_W    = 2 * PORT_W;
    localparam int CLUSTER_W = 10;
    localparam int VAL_W     = 16;
    localparam int SUM_W     = 48;
    localparam int DIM_W     = 7;
    localparam int PCNT_W    = 4;
    localparam int DIV_W     = 7;
    localparam int DIV_CNT_W = $clog2(DIV_W + 1);
    localparam int WGT_W     = 2 * VAL_W;
    localparam int ACC_DW    = 2 * ACC_WIDTH;
    localparam int APB_AW    = 5;
    localparam int APB_DW    = 32;

    // opcodes
    localparam logic [1:0] OP_TX_WEIGHT = 2'd0;
    localparam logic [1:0] OP_RX_WEIGHT = 2'd1;
    localparam logic [1:0] OP_COEF      = 2'd2;

    // register indexes
    localparam logic [2:0] REG_TX_ROWS    = 3'd0;
    localparam logic [2:0] REG_TX_COLUMNS = 3'd1;
    localparam logic [2:0] REG_TX_H_PORTS = 3'd2;
    localparam logic [2:0] REG_TX_V_PORTS = 3'd3;
    localparam logic [2:0] REG_RX_ROWS    = 3'd4;
    localparam logic [2:0] REG_RX_COLUMNS = 3'd5;
    localparam logic [2:0] REG_RX_H_PORTS = 3'd6;
    localparam logic [2:0] REG_RX_V_PORTS = 3'd7;

    localparam logic [DIM_W-1:0]  RST_ROWS    = 7'd2;
    localparam logic [DIM_W-1:0]  RST_COLUMNS = 7'd4;
    localparam logic [PCNT_W-1:0] RST_H_PORTS = 4'd1;
    localparam logic [PCNT_W-1:0] RST_V_PORTS = 4'd1;

    typedef struct packed {
        logic [1:0]              opcode;
        logic [ELEM_W-1:0]       rx_elem;
        logic [ELEM_W-1:0]       tx_elem;
        logic signed [VAL_W-1:0] value_re;
        logic signed [VAL_W-1:0] value_im;
        logic                    page_end;
    } in_item_t;

    typedef struct packed {
        logic [CLUSTER_W-1:0]    cluster;
        logic [PORT_W-1:0]       tx_port;
        logic [PORT_W-1:0]       rx_port;
        logic signed [SUM_W-1:0] sum_re;
        logic signed [SUM_W-1:0] sum_im;
        logic                    last;
    } out_item_t;

    typedef struct packed {
        logic [DIM_W-1:0]  rows;
        logic [DIM_W-1:0]  columns;
        logic [PCNT_W-1:0] h_ports;
        logic [PCNT_W-1:0] v_ports;
    } array_cfg_t;

    typedef struct packed {
        array_cfg_t tx;
        array_cfg_t rx;
    } cfg_t;

    // quotients and remainders gathered while mapping one element
    typedef struct packed {
        logic [DIV_W-1:0] he;
        logic [DIV_W-1:0] ve;
        logic [DIV_W-1:0] row;
        logic [DIV_W-1:0] col;
        logic [DIV_W-1:0] hpi;
        logic [DIV_W-1:0] cmod;
        logic [DIV_W-1:0] vpi;
        logic [DIV_W-1:0] rmod;
    } div_res_t;

    typedef struct packed {
        logic              ok;
        logic [PORT_W-1:0] port;
        logic [SLOT_W-1:0] slot;
    } map_t;

    typedef enum logic [2:0] {
        DIV_H_SIZE,
        DIV_V_SIZE,
        DIV_ELEM,
        DIV_COL,
        DIV_ROW
    } div_step_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_EVAL,
        ST_READ,
        ST_MUL1,
        ST_SUM1,
        ST_MUL2,
        ST_SUM2,
        ST_ACC,
        ST_EMIT_RD,
        ST_EMIT_LOAD,
        ST_CLEAR
    } state_t;

    typedef struct packed {
        logic      item_load;
        logic      div_start;
        div_step_t div_step;
        logic      eval;
        logic      mul1;
        logic      sum1;
        logic      mul2;
        logic      sum2;
        logic      acc_write;
        logic      emit_init;
        logic      emit_sel;
        logic      emit_load;
        logic      clear;
    } dp_cmd_t;

    typedef struct packed {
        logic [1:0] in_op;
        logic       page_end;
        logic       div_done;
        logic       emit_empty;
        logic       pair_last;
        logic       out_free;
    } dp_sts_t;

endpackage

### hw/rtl/beamformed_port_channel_combiner_core.sv
// weight write: written when accepted in the idle state. channel coefficient: five passes of
// the 7-bit bit-serial dividers plus 7 multiply/accumulate steps.
// cluster end: a read state and a load state per emitted port pair, then a clear
// state; the load state waits under m_ready back-pressure.
// aresetn is synchronous: registers go to their defaults, weights and sums read zero.
// ----------------------------------------------------------------------------
// beamformed_port_channel_combiner_core
// Weighted sub-array port combiner of complex channel coefficients.
// ----------------------------------------------------------------------------
module beamformed_port_channel_combiner_core (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bpcc_pkg::APB_AW-1:0]  paddr,
    input  logic [bpcc_pkg::APB_DW-1:0]  pwdata,
    output logic [bpcc_pkg::APB_DW-1:0]  prdata,
    output logic                         pready,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  bpcc_pkg::in_item_t           s_data,
    output logic                         m_valid,
    input  logic                         m_ready,
    output bpcc_pkg::out_item_t          m_data
);
    import bpcc_pkg::*;

    cfg_t       cfg_reg;
    logic [2:0] reg_idx;
    logic       cfg_we;
    dp_cmd_t    cmd;
    dp_sts_t    sts;

    assign pready  = 1'b1;
    assign reg_idx = paddr[APB_AW-1:2];
    assign cfg_we  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.tx.rows    <= RST_ROWS;
            cfg_reg.tx.columns <= RST_COLUMNS;
            cfg_reg.tx.h_ports <= RST_H_PORTS;
            cfg_reg.tx.v_ports <= RST_V_PORTS;
            cfg_reg.rx.rows    <= RST_ROWS;
            cfg_reg.rx.columns <= RST_COLUMNS;
            cfg_reg.rx.h_ports <= RST_H_PORTS;
            cfg_reg.rx.v_ports <= RST_V_PORTS;
        end else if (cfg_we) begin
            case (reg_idx)
                REG_TX_ROWS:    cfg_reg.tx.rows    <= pwdata[DIM_W-1:0];
                REG_TX_COLUMNS: cfg_reg.tx.columns <= pwdata[DIM_W-1:0];
                REG_TX_H_PORTS: cfg_reg.tx.h_ports <= pwdata[PCNT_W-1:0];
                REG_TX_V_PORTS: cfg_reg.tx.v_ports <= pwdata[PCNT_W-1:0];
                REG_RX_ROWS:    cfg_reg.rx.rows    <= pwdata[DIM_W-1:0];
                REG_RX_COLUMNS: cfg_reg.rx.columns <= pwdata[DIM_W-1:0];
                REG_RX_H_PORTS: cfg_reg.rx.h_ports <= pwdata[PCNT_W-1:0];
                REG_RX_V_PORTS: cfg_reg.rx.v_ports <= pwdata[PCNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_TX_ROWS:    prdata = APB_DW'(cfg_reg.tx.rows);
            REG_TX_COLUMNS: prdata = APB_DW'(cfg_reg.tx.columns);
            REG_TX_H_PORTS: prdata = APB_DW'(cfg_reg.tx.h_ports);
            REG_TX_V_PORTS: prdata = APB_DW'(cfg_reg.tx.v_ports);
            REG_RX_ROWS:    prdata = APB_DW'(cfg_reg.rx.rows);
            REG_RX_COLUMNS: prdata = APB_DW'(cfg_reg.rx.columns);
            REG_RX_H_PORTS: prdata = APB_DW'(cfg_reg.rx.h_ports);
            REG_RX_V_PORTS: prdata = APB_DW'(cfg_reg.rx.v_ports);
            default:        prdata = '0;
        endcase
    end

    bpcc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    bpcc_datapath u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .s_data  (s_data),
        .cmd     (cmd),
        .sts     (sts),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // a coefficient transaction keeps the input closed while it is worked on
    a_coef_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_data.opcode == OP_COEF |=> !s_ready)
        else $error("input reopened right after a coefficient");

    a_div_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        sts.div_done |-> !s_ready)
        else $error("divider finished while idle");

    // a held result must never be overwritten
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit_load |-> !(m_valid && !m_ready))
        else $error("result register overwritten");

endmodule

### hw/rtl/bpcc_ram.sv
// ----------------------------------------------------------------------------
// bpcc_ram
// Simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module bpcc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/bpcc_div.sv
// ----------------------------------------------------------------------------
// bpcc_div
// Restoring divider for small unsigned operands, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bpcc_div (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [bpcc_pkg::DIV_W-1:0] num,
    input  logic [bpcc_pkg::DIV_W-1:0] den,
    output logic                      done,
    output logic [bpcc_pkg::DIV_W-1:0] quo,
    output logic [bpcc_pkg::DIV_W-1:0] rem
);
    import bpcc_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_W-1:0]     num_reg, den_reg, quo_reg, rem_reg;
    logic [DIV_W:0]       shifted;
    logic                 fits;

    assign shifted = {rem_reg, num_reg[DIV_W-1]};
    assign fits    = shifted >= {1'b0, den_reg};

    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(DIV_W);
        end else if (busy_reg) begin
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            num_reg <= num;
            den_reg <= den;
            quo_reg <= '0;
            rem_reg <= '0;
        end else if (busy_reg) begin
            num_reg <= {num_reg[DIV_W-2:0], 1'b0};
            quo_reg <= {quo_reg[DIV_W-2:0], fits};
            rem_reg <= fits ? DIV_W'(shifted - {1'b0, den_reg}) : shifted[DIV_W-1:0];
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;
    assign rem  = rem_reg;

endmodule

### hw/rtl/bpcc_datapath.sv
// ----------------------------------------------------------------------------
// bpcc_datapath
// Weight stores, element mapping, weight combine, pair accumulators and
// the result register.
// ----------------------------------------------------------------------------
module bpcc_datapath (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  bpcc_pkg::cfg_t       cfg,
    input  bpcc_pkg::in_item_t   s_data,
    input  bpcc_pkg::dp_cmd_t    cmd,
    output bpcc_pkg::dp_sts_t    sts,
    output logic                 m_valid,
    input  logic                 m_ready,
    output bpcc_pkg::out_item_t  m_data
);
    import bpcc_pkg::*;

    function automatic logic [PCNT_W-1:0] port_count(array_cfg_t c);
        logic [2*PCNT_W-1:0] n;
        logic [PCNT_W-1:0]   res;
        n = (2*PCNT_W)'(c.h_ports) * (2*PCNT_W)'(c.v_ports);
        if (c.rows == '0 || c.columns == '0 || c.h_ports == '0 || c.v_ports == '0 ||
            c.columns < DIM_W'(c.h_ports) || c.rows < DIM_W'(c.v_ports)) begin
            res = '0;
        end else if (n > (2*PCNT_W)'(MAX_PORTS)) begin
            res = PCNT_W'(MAX_PORTS);
        end else begin
            res = n[PCNT_W-1:0];
        end
        return res;
    endfunction

    function automatic map_t map_elem(array_cfg_t c, div_res_t d, logic [ELEM_W-1:0] e);
        map_t        m;
        logic [13:0] area;
        logic [11:0] port;
        logic [14:0] slot;
        area = 14'(c.rows) * 14'(c.columns);
        port = 12'(d.hpi) * 12'(c.v_ports) + 12'(d.vpi);
        slot = 15'(d.rmod) * 15'(c.columns) + 15'(d.cmod);
        m.ok = c.rows != '0 && c.columns != '0 && c.h_ports != '0 && c.v_ports != '0 &&
               d.he != '0 && d.ve != '0 && 14'(e) < area && 11'(e) < 11'(MAX_ELEMS) &&
               d.hpi < DIV_W'(c.h_ports) && d.vpi < DIV_W'(c.v_ports) &&
               port < 12'(MAX_PORTS) && slot < 15'(MAX_ELEMS);
        m.port = port[PORT_W-1:0];
        m.slot = slot[SLOT_W-1:0];
        return m;
    endfunction

    // round half up to Q2.15, saturate to 17 signed bits
    function automatic logic signed [16:0] round_q215(logic signed [32:0] x);
        logic signed [33:0] v;
        logic signed [18:0] r;
        logic signed [16:0] res;
        v = 34'(x) + 34'sd16384;
        r = 19'(v >>> 15);
        if (r > 19'sd65535) begin
            res = 17'sd65535;
        end else if (r < -19'sd65536) begin
            res = -17'sd65536;
        end else begin
            res = r[16:0];
        end
        return res;
    endfunction

    function automatic logic signed [ACC_WIDTH-1:0] sat_add(logic signed [ACC_WIDTH-1:0] a,
                                                          logic signed [33:0] t);
        logic signed [ACC_WIDTH:0]   s;
        logic signed [ACC_WIDTH-1:0] res;
        s = (ACC_WIDTH+1)'(a) + (ACC_WIDTH+1)'(t);
        if (s[ACC_WIDTH] != s[ACC_WIDTH-1]) begin
            res = s[ACC_WIDTH] ? {1'b1, {(ACC_WIDTH-1){1'b0}}} : {1'b0, {(ACC_WIDTH-1){1'b1}}};
        end else begin
            res = s[ACC_WIDTH-1:0];
        end
        return res;
    endfunction

    in_item_t item_reg;

    // weight stores
    logic [MAX_ELEMS-1:0] tx_wvld_reg, rx_wvld_reg;
    logic                 tx_we, rx_we;
    logic [WGT_W-1:0]     tx_rdata, rx_rdata;
    map_t                 tx_map_reg, rx_map_reg;

    assign tx_we = cmd.item_load && s_data.opcode == OP_TX_WEIGHT;
    assign rx_we = cmd.item_load && s_data.opcode == OP_RX_WEIGHT;

    bpcc_ram #(.WIDTH(WGT_W), .DEPTH(MAX_ELEMS)) u_tx_wgt (
        .aclk  (aclk),
        .we    (tx_we),
        .waddr (s_data.tx_elem[SLOT_W-1:0]),
        .wdata ({s_data.value_re, s_data.value_im}),
        .raddr (tx_map_reg.slot),
        .rdata (tx_rdata)
    );

    bpcc_ram #(.WIDTH(WGT_W), .DEPTH(MAX_ELEMS)) u_rx_wgt (
        .aclk  (aclk),
        .we    (rx_we),
        .waddr (s_data.rx_elem[SLOT_W-1:0]),
        .wdata ({s_data.value_re, s_data.value_im}),
        .raddr (rx_map_reg.slot),
        .rdata (rx_rdata)
    );

    // element mapping, one divider per array
    div_res_t         tx_div_reg, rx_div_reg;
    logic [DIV_W-1:0] tx_num, tx_den, rx_num, rx_den;
    logic [DIV_W-1:0] tx_quo, tx_rem, rx_quo, rx_rem;
    logic             tx_done, rx_done;

    always_comb begin
        case (cmd.div_step)
            DIV_H_SIZE: begin
                tx_num = cfg.tx.columns;  tx_den = DIV_W'(cfg.tx.h_ports);
                rx_num = cfg.rx.columns;  rx_den = DIV_W'(cfg.rx.h_ports);
            end
            DIV_V_SIZE: begin
                tx_num = cfg.tx.rows;     tx_den = DIV_W'(cfg.tx.v_ports);
                rx_num = cfg.rx.rows;     rx_den = DIV_W'(cfg.rx.v_ports);
            end
            DIV_ELEM: begin
                tx_num = DIV_W'(item_reg.tx_elem);  tx_den = cfg.tx.columns;
                rx_num = DIV_W'(item_reg.rx_elem);  rx_den = cfg.rx.columns;
            end
            DIV_COL: begin
                tx_num = tx_div_reg.col;  tx_den = tx_div_reg.he;
                rx_num = rx_div_reg.col;  rx_den = rx_div_reg.he;
            end
            DIV_ROW: begin
                tx_num = tx_div_reg.row;  tx_den = tx_div_reg.ve;
                rx_num = rx_div_reg.row;  rx_den = rx_div_reg.ve;
            end
            default: begin
                tx_num = '0;  tx_den = '0;
                rx_num = '0;  rx_den = '0;
            end
        endcase
    end

    bpcc_div u_tx_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .num     (tx_num),
        .den     (tx_den),
        .done    (tx_done),
        .quo     (tx_quo),
        .rem     (tx_rem)
    );

    bpcc_div u_rx_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .num     (rx_num),
        .den     (rx_den),
        .done    (rx_done),
        .quo     (rx_quo),
        .rem     (rx_rem)
    );

    assign sts.div_done = tx_done && rx_done;

    always_ff @(posedge aclk) begin
        if (cmd.item_load) begin
            item_reg <= s_data;
        end
        if (sts.div_done) begin
            case (cmd.div_step)
                DIV_H_SIZE: begin
                    tx_div_reg.he <= tx_quo;
                    rx_div_reg.he <= rx_quo;
                end
                DIV_V_SIZE: begin
                    tx_div_reg.ve <= tx_quo;
                    rx_div_reg.ve <= rx_quo;
                end
                DIV_ELEM: begin
                    tx_div_reg.row <= tx_quo;  tx_div_reg.col <= tx_rem;
                    rx_div_reg.row <= rx_quo;  rx_div_reg.col <= rx_rem;
                end
                DIV_COL: begin
                    tx_div_reg.hpi <= tx_quo;  tx_div_reg.cmod <= tx_rem;
                    rx_div_reg.hpi <= rx_quo;  rx_div_reg.cmod <= rx_rem;
                end
                DIV_ROW: begin
                    tx_div_reg.vpi <= tx_quo;  tx_div_reg.rmod <= tx_rem;
                    rx_div_reg.vpi <= rx_quo;  rx_div_reg.rmod <= rx_rem;
                end
                default: begin
                end
            endcase
        end
        if (cmd.eval) begin
            tx_map_reg <= map_elem(cfg.tx, tx_div_reg, item_reg.tx_elem);
            rx_map_reg <= map_elem(cfg.rx, rx_div_reg, item_reg.rx_elem);
        end
    end

    // weight combine and coefficient product
    logic signed [VAL_W-1:0] u_re, u_im, w_re, w_im;
    logic signed [31:0]      p_rs_reg, p_ii_reg, p_ri_reg, p_ir_reg;
    logic signed [16:0]      wr_reg, wi_reg;
    logic signed [32:0]      q_rr_reg, q_ii_reg, q_ri_reg, q_ir_reg;
    logic signed [33:0]      term_re_reg, term_im_reg;

    assign u_re = rx_wvld_reg[rx_map_reg.slot] ? rx_rdata[WGT_W-1:VAL_W] : '0;
    assign u_im = rx_wvld_reg[rx_map_reg.slot] ? rx_rdata[VAL_W-1:0]     : '0;
    assign w_re = tx_wvld_reg[tx_map_reg.slot] ? tx_rdata[WGT_W-1:VAL_W] : '0;
    assign w_im = tx_wvld_reg[tx_map_reg.slot] ? tx_rdata[VAL_W-1:0]     : '0;

    always_ff @(posedge aclk) begin
        if (cmd.mul1) begin
            p_rs_reg <= 32'(u_re) * 32'(w_re);
            p_ii_reg <= 32'(u_im) * 32'(w_im);
            p_ri_reg <= 32'(u_re) * 32'(w_im);
            p_ir_reg <= 32'(u_im) * 32'(w_re);
        end
        if (cmd.sum1) begin
            wr_reg <= round_q215(33'(p_rs_reg) + 33'(p_ii_reg));
            wi_reg <= round_q215(33'(p_ri_reg) - 33'(p_ir_reg));
        end
        if (cmd.mul2) begin
            q_rr_reg <= 33'(wr_reg) * 33'(item_reg.value_re);
            q_ii_reg <= 33'(wi_reg) * 33'(item_reg.value_im);
            q_ri_reg <= 33'(wr_reg) * 33'(item_reg.value_im);
            q_ir_reg <= 33'(wi_reg) * 33'(item_reg.value_re);
        end
        if (cmd.sum2) begin
            term_re_reg <= 34'(q_rr_reg) - 34'(q_ii_reg);
            term_im_reg <= 34'(q_ri_reg) + 34'(q_ir_reg);
        end
    end

    // pair accumulators
    logic [PORT_W-1:0]                 emit_t_reg, emit_r_reg;
    logic [PAIR_W-1:0]                 acc_addr;
    logic [MAX_PORTS*MAX_PORTS-1:0]    acc_vld_reg;
    logic [ACC_DW-1:0]                 acc_rdata;
    logic signed [ACC_WIDTH-1:0]       acc_re, acc_im;
    logic                              acc_we;
    logic [ACC_DW-1:0]                 acc_wdata;

    assign acc_addr = cmd.emit_sel ? {emit_t_reg, emit_r_reg}
                                   : {tx_map_reg.port, rx_map_reg.port};
    assign acc_re   = acc_vld_reg[acc_addr] ? acc_rdata[ACC_DW-1:ACC_WIDTH] : '0;
    assign acc_im   = acc_vld_reg[acc_addr] ? acc_rdata[ACC_WIDTH-1:0]      : '0;
    assign acc_we   = cmd.acc_write && tx_map_reg.ok && rx_map_reg.ok;
    assign acc_wdata = {sat_add(acc_re, term_re_reg), sat_add(acc_im, term_im_reg)};

    bpcc_ram #(.WIDTH(ACC_DW), .DEPTH(MAX_PORTS * MAX_PORTS)) u_acc (
        .aclk  (aclk),
        .we    (acc_we),
        .waddr (acc_addr),
        .wdata (acc_wdata),
        .raddr (acc_addr),
        .rdata (acc_rdata)
    );

    // emission
    logic [PCNT_W-1:0]    n_tx, n_rx;
    logic                 r_wrap;
    logic [CLUSTER_W-1:0] cluster_reg;
    logic                 m_valid_reg;
    out_item_t            m_data_reg;

    assign n_tx   = port_count(cfg.tx);
    assign n_rx   = port_count(cfg.rx);
    assign r_wrap = PCNT_W'(emit_r_reg) + 1'b1 == n_rx;

    assign sts.in_op      = s_data.opcode;
    assign sts.page_end   = item_reg.page_end;
    assign sts.emit_empty = n_tx == '0 || n_rx == '0;
    assign sts.pair_last  = r_wrap && PCNT_W'(emit_t_reg) + 1'b1 == n_tx;
    assign sts.out_free   = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tx_wvld_reg <= '0;
            rx_wvld_reg <= '0;
            acc_vld_reg <= '0;
            cluster_reg <= '0;
            emit_t_reg  <= '0;
            emit_r_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (tx_we) begin
                tx_wvld_reg[s_data.tx_elem[SLOT_W-1:0]] <= 1'b1;
            end
            if (rx_we) begin
                rx_wvld_reg[s_data.rx_elem[SLOT_W-1:0]] <= 1'b1;
            end
            if (cmd.clear) begin
                acc_vld_reg <= '0;
                cluster_reg <= cluster_reg + 1'b1;
            end else if (acc_we) begin
                acc_vld_reg[acc_addr] <= 1'b1;
            end
            if (cmd.emit_init) begin
                emit_t_reg <= '0;
                emit_r_reg <= '0;
            end else if (cmd.emit_load) begin
                if (r_wrap) begin
                    emit_r_reg <= '0;
                    emit_t_reg <= emit_t_reg + 1'b1;
                end else begin
                    emit_r_reg <= emit_r_reg + 1'b1;
                end
            end
            if (cmd.emit_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit_load) begin
            m_data_reg.cluster <= cluster_reg;
            m_data_reg.tx_port <= emit_t_reg;
            m_data_reg.rx_port <= emit_r_reg;
            m_data_reg.sum_re  <= SUM_W'(acc_re);
            m_data_reg.sum_im  <= SUM_W'(acc_im);
            m_data_reg.last    <= sts.pair_last;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

### hw/rtl/bpcc_ctrl.sv
// ----------------------------------------------------------------------------
// bpcc_ctrl
// Sequencer: accepts items, steps the mapping dividers, the multiply and
// accumulate stages and the emission of port-pair sums.
// ----------------------------------------------------------------------------
module bpcc_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    output bpcc_pkg::dp_cmd_t   cmd,
    input  bpcc_pkg::dp_sts_t   sts
);
    import bpcc_pkg::*;

    state_t    state_reg, state_next;
    div_step_t step_reg, step_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= DIV_H_SIZE;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid && sts.in_op == OP_COEF) begin
                    state_next = ST_DIV_START;
                    step_next  = DIV_H_SIZE;
                end
            end
            ST_DIV_START: state_next = ST_DIV_WAIT;
            ST_DIV_WAIT: begin
                if (sts.div_done) begin
                    if (step_reg == DIV_ROW) begin
                        state_next = ST_EVAL;
                    end else begin
                        step_next  = div_step_t'(step_reg + 3'd1);
                        state_next = ST_DIV_START;
                    end
                end
            end
            ST_EVAL: state_next = ST_READ;
            ST_READ: state_next = ST_MUL1;
            ST_MUL1: state_next = ST_SUM1;
            ST_SUM1: state_next = ST_MUL2;
            ST_MUL2: state_next = ST_SUM2;
            ST_SUM2: state_next = ST_ACC;
            ST_ACC: begin
                if (!sts.page_end) begin
                    state_next = ST_IDLE;
                end else if (sts.emit_empty) begin
                    state_next = ST_CLEAR;
                end else begin
                    state_next = ST_EMIT_RD;
                end
            end
            ST_EMIT_RD: state_next = ST_EMIT_LOAD;
            ST_EMIT_LOAD: begin
                if (sts.out_free) begin
                    state_next = sts.pair_last ? ST_CLEAR : ST_EMIT_RD;
                end
            end
            ST_CLEAR: state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd          = '0;
        cmd.div_step = step_reg;
        s_ready      = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready       = 1'b1;
                cmd.item_load = s_valid;
            end
            ST_DIV_START: cmd.div_start = 1'b1;
            ST_EVAL:      cmd.eval      = 1'b1;
            ST_MUL1:      cmd.mul1      = 1'b1;
            ST_SUM1:      cmd.sum1      = 1'b1;
            ST_MUL2:      cmd.mul2      = 1'b1;
            ST_SUM2:      cmd.sum2      = 1'b1;
            ST_ACC: begin
                cmd.acc_write = 1'b1;
                cmd.emit_init = 1'b1;
            end
            ST_EMIT_RD: cmd.emit_sel = 1'b1;
            ST_EMIT_LOAD: begin
                cmd.emit_sel  = 1'b1;
                cmd.emit_load = sts.out_free;
            end
            ST_CLEAR: cmd.clear = 1'b1;
            default: begin
            end
        endcase
    end

endmodule

### test/beamformed_port_channel_combiner_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// beamformed_port_channel_combiner_core_tb
// Checks the port channel combiner against a behavioral copy of its weight
// stores, element-to-port mapping and saturating port-pair sums, over several
// array layouts and with random idle and stall phases on both channels.
// ----------------------------------------------------------------------------
module beamformed_port_channel_combiner_core_tb;
    import bpcc_pkg::*;

    localparam int PERIOD      = 8;
    localparam int CYCLE_LIMIT = 3000000;

    logic                aclk;
    logic                aresetn;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [APB_AW-1:0]   paddr;
    logic [APB_DW-1:0]   pwdata;
    logic [APB_DW-1:0]   prdata;
    logic                pready;
    logic                s_valid;
    logic                s_ready;
    in_item_t            s_data;
    logic                m_valid;
    logic                m_ready;
    out_item_t           m_data;

    beamformed_port_channel_combiner_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    // predictor state
    int unsigned     cfg_regs[8];
    logic signed [15:0] tx_w_re[64], tx_w_im[64], rx_w_re[64], rx_w_im[64];
    longint          acc_re[64], acc_im[64];
    int unsigned     cluster_num;

    in_item_t        pending_items[$];
    out_item_t       expected_sums[$];
    int              sender_idle_pct;
    int              receiver_stall_pct;
    int              errors;
    longint          cycles;

    initial begin
        aclk = 1'b0;
        forever #(PERIOD / 2) aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic int unsigned ports_of(int unsigned rows, int unsigned cols,
                                             int unsigned hp, int unsigned vp);
        int unsigned n;
        if (rows == 0 || cols == 0 || hp == 0 || vp == 0) return 0;
        if (cols / hp == 0 || rows / vp == 0) return 0;
        n = hp * vp;
        return (n > MAX_PORTS) ? MAX_PORTS : n;
    endfunction

    function automatic bit locate_elem(int unsigned base, int unsigned e,
                                       output int unsigned port,
                                       output int unsigned slot);
        int unsigned rows, cols, hp, vp, he, ve, row, col, hpi, vpi;
        rows = cfg_regs[base];
        cols = cfg_regs[base + 1];
        hp   = cfg_regs[base + 2];
        vp   = cfg_regs[base + 3];
        port = 0;
        slot = 0;
        if (ports_of(rows, cols, hp, vp) == 0) return 0;
        if (e >= rows * cols || e >= MAX_ELEMS) return 0;
        he  = cols / hp;
        ve  = rows / vp;
        row = e / cols;
        col = e % cols;
        hpi = col / he;
        vpi = row / ve;
        if (hpi >= hp || vpi >= vp) return 0;
        port = hpi * vp + vpi;
        if (port >= MAX_PORTS) return 0;
        slot = (row % ve) * cols + (col % he);
        return slot < MAX_ELEMS;
    endfunction

    function automatic longint round_weight(longint x);
        longint v;
        v = (x + 16384) >>> 15;
        if (v > 65535) v = 65535;
        if (v < -65536) v = -65536;
        return v;
    endfunction

    function automatic longint sat_sum(longint a, longint t);
        longint mx, mn;
        mx = (64'sd1 <<< (ACC_WIDTH - 1)) - 1;
        mn = -mx - 1;
        if (t > 0 && a > mx - t) return mx;
        if (t < 0 && a < mn - t) return mn;
        return a + t;
    endfunction

    task automatic predict_sums(input in_item_t it);
        int unsigned tp, ts, rp, rs, nt, nr;
        longint ur, ui, sr, si, wr, wi, vr, vi;
        out_item_t o;
        vr = it.value_re;
        vi = it.value_im;
        if (it.opcode == OP_TX_WEIGHT) begin
            tx_w_re[it.tx_elem] = it.value_re;
            tx_w_im[it.tx_elem] = it.value_im;
            return;
        end
        if (it.opcode == OP_RX_WEIGHT) begin
            rx_w_re[it.rx_elem] = it.value_re;
            rx_w_im[it.rx_elem] = it.value_im;
            return;
        end
        if (it.opcode != OP_COEF) return;
        if (locate_elem(0, it.tx_elem, tp, ts) && locate_elem(4, it.rx_elem, rp, rs)) begin
            ur = rx_w_re[rs]; ui = rx_w_im[rs];
            sr = tx_w_re[ts]; si = tx_w_im[ts];
            wr = round_weight(ur * sr + ui * si);
            wi = round_weight(ur * si - ui * sr);
            acc_re[tp * 8 + rp] = sat_sum(acc_re[tp * 8 + rp], wr * vr - wi * vi);
            acc_im[tp * 8 + rp] = sat_sum(acc_im[tp * 8 + rp], wr * vi + wi * vr);
        end
        if (!it.page_end) return;
        nt = ports_of(cfg_regs[0], cfg_regs[1], cfg_regs[2], cfg_regs[3]);
        nr = ports_of(cfg_regs[4], cfg_regs[5], cfg_regs[6], cfg_regs[7]);
        for (int t = 0; t < nt; t++) begin
            for (int r = 0; r < nr; r++) begin
                o.cluster = cluster_num[9:0];
                o.tx_port = t[2:0];
                o.rx_port = r[2:0];
                o.sum_re  = acc_re[t * 8 + r][47:0];
                o.sum_im  = acc_im[t * 8 + r][47:0];
                o.last    = (t + 1 == nt && r + 1 == nr);
                expected_sums.push_back(o);
            end
        end
        for (int k = 0; k < 64; k++) begin
            acc_re[k] = 0;
            acc_im[k] = 0;
        end
        cluster_num = (cluster_num + 1) % 1024;
    endtask

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (pending_items.size() > 0 &&
                $urandom_range(99, 0) >= sender_idle_pct) begin
                s_data  <= pending_items.pop_front();
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // prediction follows each accepted transaction
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) predict_sums(s_data);
    end

    // monitor
    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn) begin
            m_ready <= ($urandom_range(99, 0) >= receiver_stall_pct);
            if (m_valid && m_ready) begin
                if (expected_sums.size() == 0) begin
                    $error("unexpected result cluster=%0d", m_data.cluster);
                    errors++;
                end else begin
                    want = expected_sums.pop_front();
                    if (m_data.cluster !== want.cluster) begin
                        $error("cluster exp %0d got %0d", want.cluster, m_data.cluster);
                        errors++;
                    end
                    if (m_data.tx_port !== want.tx_port) begin
                        $error("tx_port exp %0d got %0d", want.tx_port, m_data.tx_port);
                        errors++;
                    end
                    if (m_data.rx_port !== want.rx_port) begin
                        $error("rx_port exp %0d got %0d", want.rx_port, m_data.rx_port);
                        errors++;
                    end
                    if (m_data.sum_re !== want.sum_re) begin
                        $error("sum_re exp %0d got %0d", want.sum_re, m_data.sum_re);
                        errors++;
                    end
                    if (m_data.sum_im !== want.sum_im) begin
                        $error("sum_im exp %0d got %0d", want.sum_im, m_data.sum_im);
                        errors++;
                    end
                    if (m_data.last !== want.last) begin
                        $error("last exp %0d got %0d", want.last, m_data.last);
                        errors++;
                    end
                end
            end
        end
    end

    task automatic write_reg(input logic [2:0] idx, input int unsigned value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cfg_regs[idx] = (idx[1]) ? (value & 4'hf) : (value & 7'h7f);
    endtask

    task automatic set_layout(input int unsigned tr, tc, th, tv, rr, rc, rh, rv);
        write_reg(REG_TX_ROWS, tr);
        write_reg(REG_TX_COLUMNS, tc);
        write_reg(REG_TX_H_PORTS, th);
        write_reg(REG_TX_V_PORTS, tv);
        write_reg(REG_RX_ROWS, rr);
        write_reg(REG_RX_COLUMNS, rc);
        write_reg(REG_RX_H_PORTS, rh);
        write_reg(REG_RX_V_PORTS, rv);
    endtask

    task automatic add_item(input logic [1:0] op, input int unsigned re_e, te_e,
                            input logic [15:0] vr, vi, input bit pe);
        in_item_t it;
        it.opcode   = op;
        it.rx_elem  = re_e[5:0];
        it.tx_elem  = te_e[5:0];
        it.value_re = vr;
        it.value_im = vi;
        it.page_end = pe;
        pending_items.push_back(it);
    endtask

    // four random weight writes, then one cluster of mostly coefficients
    task automatic add_cluster(input int unsigned n_coef, input bit big);
        logic [15:0] vr, vi;
        for (int k = 0; k < 4; k++) begin
            vr = big ? ($urandom_range(1) ? 16'h7fff : 16'h8000) : 16'($urandom);
            vi = big ? ($urandom_range(1) ? 16'h7fff : 16'h8000) : 16'($urandom);
            add_item(2'($urandom_range(1)), $urandom_range(63), $urandom_range(63), vr, vi,
                     1'($urandom_range(1)));
        end
        for (int k = 0; k < n_coef; k++) begin
            vr = big ? ($urandom_range(1) ? 16'h7fff : 16'h8000) : 16'($urandom);
            vi = big ? ($urandom_range(1) ? 16'h7fff : 16'h8000) : 16'($urandom);
            if ($urandom_range(19) == 0)
                add_item(2'($urandom_range(3)), $urandom_range(63), $urandom_range(63),
                         vr, vi, 0);
            else
                add_item(OP_COEF, $urandom_range(63), $urandom_range(63), vr, vi, 0);
        end
        add_item(OP_COEF, $urandom_range(63), $urandom_range(63), 16'($urandom),
                 16'($urandom), 1);
    endtask

    // wait out all results plus the slowest coefficient still in flight
    task automatic drain;
        wait (pending_items.size() == 0 && !s_valid);
        wait (expected_sums.size() == 0);
        repeat (200) @(posedge aclk);
    endtask

    task automatic set_idling(input int phase);
        case (phase % 4)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 87; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 87; end
            default: begin sender_idle_pct = 14; receiver_stall_pct = 14; end
        endcase
    endtask

    initial begin
        cycles = 0;
        errors = 0;
        cluster_num = 0;
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        cfg_regs = '{2, 4, 1, 1, 2, 4, 1, 1};
        for (int k = 0; k < 64; k++) begin
            tx_w_re[k] = 0; tx_w_im[k] = 0; rx_w_re[k] = 0; rx_w_im[k] = 0;
            acc_re[k] = 0; acc_im[k] = 0;
        end
        aresetn = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        s_valid = 1'b0; s_data = '0; m_ready = 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: reset layout, extremes, all opcodes
        add_item(OP_COEF, 0, 0, 16'h7fff, 16'h7fff, 1);
        add_item(OP_TX_WEIGHT, 63, 0, 16'h7fff, 16'h8000, 1);
        add_item(OP_TX_WEIGHT, 0, 63, 16'h8000, 16'h8000, 0);
        add_item(OP_RX_WEIGHT, 0, 0, 16'h8000, 16'h8000, 0);
        add_item(OP_TX_WEIGHT, 0, 0, 16'h8000, 16'h8000, 0);
        add_item(OP_RX_WEIGHT, 63, 63, 16'h7fff, 16'h7fff, 0);
        add_item(2'd3, 63, 63, 16'hffff, 16'hffff, 1);
        for (int k = 0; k < 6; k++) add_item(OP_COEF, 0, 0, 16'h8000, 16'h7fff, 0);
        add_item(OP_COEF, 63, 63, 16'h8000, 16'h8000, 0);
        add_item(OP_COEF, 7, 7, 16'h7fff, 16'h8000, 1);
        drain();

        // degenerate and extreme layouts, then random layouts
        set_layout(0, 4, 1, 1, 64, 64, 8, 8);
        add_item(OP_COEF, 5, 5, 16'h1234, 16'h4321, 1);
        drain();
        set_layout(64, 1, 2, 1, 8, 8, 8, 8);
        add_cluster(10, 1);
        drain();
        set_layout(8, 8, 8, 8, 1, 64, 1, 1);
        add_cluster(10, 0);
        drain();

        for (int ph = 0; ph < 13; ph++) begin
            set_idling(ph);
            if (ph % 4 == 0)
                set_layout($urandom_range(1, 8), $urandom_range(1, 8), $urandom_range(1, 4),
                           $urandom_range(1, 4), $urandom_range(1, 8), $urandom_range(1, 8),
                           $urandom_range(1, 4), $urandom_range(1, 4));
            add_cluster($urandom_range(6, 20), ph == 5);
            add_cluster($urandom_range(2, 8), 0);
            drain();
        end

        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule

### filelist.f
hw/rtl/bpcc_pkg.sv
hw/rtl/bpcc_ram.sv
hw/rtl/bpcc_div.sv
hw/rtl/bpcc_datapath.sv
hw/rtl/bpcc_ctrl.sv
hw/rtl/beamformed_port_channel_combiner_core.sv
test/beamformed_port_channel_combiner_core_tb.sv
